FILE: rtl/jrb_pkg.sv
// ----------------------------------------------------------------------------
// jrb_pkg
// Shared constants, codes and types of the reorder jitter buffer.
// ----------------------------------------------------------------------------
package jrb_pkg;

  // Default geometry: frames of 20 words (160 bytes), 16 frame slots.
  localparam int unsigned WindowDef     = 16;
  localparam int unsigned FrameWordsDef = 20;

  // Field widths fixed by the stream format.
  localparam int unsigned SeqW   = 32;
  localparam int unsigned WidxW  = 5;
  localparam int unsigned DataW  = 64;

  // tdata: seq, word index, data, padded to whole bytes.
  localparam int unsigned TdataW = ((SeqW + WidxW + DataW + 7) / 8) * 8;

  // Input beat kind, carried in tuser bit 0.
  typedef enum logic {
    MODE_PACKET = 1'b0,
    MODE_PULL   = 1'b1
  } mode_e;

  // Payload section of a packet word, carried in tuser bit 1.
  typedef enum logic {
    SECT_PRIMARY   = 1'b0,
    SECT_REDUNDANT = 1'b1
  } section_e;

  // Playout word in flight between the store read and the output register.
  typedef struct packed {
    logic             valid_res;
    logic [SeqW-1:0]  seq;
    logic [WidxW-1:0] widx;
    logic             frame_end;
  } play_t;

endpackage

FILE: rtl/jrb_ram.sv
// ----------------------------------------------------------------------------
// jrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module jrb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 320,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/jitter_reorder_buffer_with_redundancy.sv
// ----------------------------------------------------------------------------
// jitter_reorder_buffer_with_redundancy
// Reorder jitter buffer for fixed frames with redundant-copy recovery.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle on the input, packet words and pulls alike,
//   unless output stall holds tready low; each beat makes at most one access
//   to the frame store RAM (one write or one read).
// Playout: pull -> pending stage (with RAM read) -> output register -> out.
// Reset: rst_ni clears slot flags, frame/word counters and the pipeline at
//   once; the frame store itself is not cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
module jitter_reorder_buffer_with_redundancy #(
  parameter int unsigned WINDOW      = jrb_pkg::WindowDef,
  parameter int unsigned FRAME_WORDS = jrb_pkg::FrameWordsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Slave side: packet words and pull requests.
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: [31:0] seq, [36:32] word_index, [100:37] data, [103:101] zero
  input  logic [jrb_pkg::TdataW-1:0] s_axis_tdata_i,
  // tuser: [0] mode, [1] section
  input  logic [1:0]                 s_axis_tuser_i,
  // Master side: playout words.
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // tdata: [31:0] out_seq, [36:32] out_word_index, [100:37] out_data,
  //        [103:101] zero
  output logic [jrb_pkg::TdataW-1:0] m_axis_tdata_o,
  // tuser: [0] valid_res
  output logic                       m_axis_tuser_o,
  // tlast: frame_end
  output logic                       m_axis_tlast_o
);

  import jrb_pkg::*;

  localparam int unsigned SlotW  = $clog2(WINDOW);
  localparam int unsigned PwW    = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int unsigned Depth  = WINDOW * FRAME_WORDS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned PadW   = TdataW - SeqW - WidxW - DataW;

  // --------------------------------------------------------------------------
  // Input beat unpacking
  // --------------------------------------------------------------------------
  logic [SeqW-1:0]  in_seq;
  logic [WidxW-1:0] in_widx;
  logic [DataW-1:0] in_data;
  mode_e            in_mode;
  section_e         in_sect;

  assign in_seq  = s_axis_tdata_i[SeqW-1:0];
  assign in_widx = s_axis_tdata_i[SeqW +: WidxW];
  assign in_data = s_axis_tdata_i[SeqW+WidxW +: DataW];
  assign in_mode = mode_e'(s_axis_tuser_i[0]);
  assign in_sect = section_e'(s_axis_tuser_i[1]);

  // --------------------------------------------------------------------------
  // Control state. Slots are numbered relative to the first frame seen, so
  // frame f sits in slot (f - first_seq) mod WINDOW; next_slot_q tracks the
  // slot of next_frame_q and next_base_q its first store address.
  // --------------------------------------------------------------------------
  logic [WINDOW-1:0] slot_full_q, slot_full_d;
  logic [SeqW-1:0]   next_frame_q, next_frame_d;
  logic [SlotW-1:0]  next_slot_q, next_slot_d;
  logic [AddrW-1:0]  next_base_q, next_base_d;
  logic              started_q, started_d;
  logic [PwW-1:0]    play_word_q, play_word_d;
  logic              write_acc_q, write_acc_d;

  logic              in_beat;
  logic              pkt_beat;
  logic              pull_beat;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign pkt_beat  = in_beat && (in_mode == MODE_PACKET);
  assign pull_beat = in_beat && (in_mode == MODE_PULL);

  // --------------------------------------------------------------------------
  // Window test for a packet word
  // --------------------------------------------------------------------------
  logic [SeqW-1:0]  nf_eff;
  logic [SlotW-1:0] ns_eff;
  logic [SeqW-1:0]  target;
  logic [SeqW-1:0]  tgt_dist;
  logic             in_window;
  logic [SlotW:0]   slot_sum;
  logic [SlotW-1:0] tgt_slot;
  logic             may_store;
  logic             widx_ok;
  logic             widx_first;
  logic             widx_last;
  logic             red_skip;

  // Before the first packet the beat itself defines the expected frame.
  assign nf_eff = started_q ? next_frame_q : in_seq;
  assign ns_eff = started_q ? next_slot_q : '0;

  assign target    = (in_sect == SECT_REDUNDANT) ? (in_seq - 1'b1) : in_seq;
  assign tgt_dist  = target - nf_eff;
  assign in_window = tgt_dist < SeqW'(WINDOW);

  // Fold the in-window offset onto the slot ring with one compare/subtract.
  assign slot_sum = {1'b0, ns_eff} + {1'b0, tgt_dist[SlotW-1:0]};
  assign tgt_slot = (slot_sum >= (SlotW+1)'(WINDOW))
                  ? SlotW'(slot_sum - (SlotW+1)'(WINDOW))
                  : SlotW'(slot_sum);

  assign may_store  = in_window && !slot_full_q[tgt_slot];
  assign widx_ok    = 32'(in_widx) < FRAME_WORDS;
  assign widx_first = in_widx == '0;
  assign widx_last  = 32'(in_widx) == FRAME_WORDS - 1;
  assign red_skip   = (in_sect == SECT_REDUNDANT) && (in_seq == '0);

  // --------------------------------------------------------------------------
  // Store access and state update
  // --------------------------------------------------------------------------
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;
  logic             exp_full;
  logic             pw_last;
  play_t            play_d;

  assign ram_waddr = AddrW'(tgt_slot) * AddrW'(FRAME_WORDS) + AddrW'(in_widx);
  assign ram_raddr = next_base_q + AddrW'(play_word_q);
  assign exp_full  = started_q && slot_full_q[next_slot_q];
  assign pw_last   = play_word_q == PwW'(FRAME_WORDS - 1);

  always_comb begin
    slot_full_d  = slot_full_q;
    next_frame_d = next_frame_q;
    next_slot_d  = next_slot_q;
    next_base_d  = next_base_q;
    started_d    = started_q;
    play_word_d  = play_word_q;
    write_acc_d  = write_acc_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    play_d.valid_res = exp_full;
    play_d.seq       = next_frame_q;
    play_d.widx      = exp_full ? WidxW'(play_word_q) : '0;
    play_d.frame_end = exp_full && pw_last;

    if (pkt_beat) begin
      started_d    = 1'b1;
      next_frame_d = nf_eff;
      if (widx_ok) begin
        if (red_skip) begin
          // Redundant copy of frame -1 does not exist: close the section.
          if (widx_first) begin
            write_acc_d = 1'b0;
          end
        end else begin
          if (widx_first) begin
            write_acc_d = may_store;
          end
          // Latch the decision on word 0, re-check it on every later word.
          if (may_store && (widx_first || write_acc_q)) begin
            ram_we = 1'b1;
            if (widx_last) begin
              slot_full_d[tgt_slot] = 1'b1;
            end
          end
        end
      end
    end

    if (pull_beat && exp_full) begin
      ram_re = 1'b1;
      if (pw_last) begin
        // Free the slot and advance to the next frame.
        slot_full_d[next_slot_q] = 1'b0;
        next_frame_d = next_frame_q + 1'b1;
        play_word_d  = '0;
        if (next_slot_q == SlotW'(WINDOW - 1)) begin
          next_slot_d = '0;
          next_base_d = '0;
        end else begin
          next_slot_d = next_slot_q + 1'b1;
          next_base_d = next_base_q + AddrW'(FRAME_WORDS);
        end
      end else begin
        play_word_d = play_word_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_full_q  <= '0;
      next_frame_q <= '0;
      next_slot_q  <= '0;
      next_base_q  <= '0;
      started_q    <= 1'b0;
      play_word_q  <= '0;
      write_acc_q  <= 1'b0;
    end else begin
      slot_full_q  <= slot_full_d;
      next_frame_q <= next_frame_d;
      next_slot_q  <= next_slot_d;
      next_base_q  <= next_base_d;
      started_q    <= started_d;
      play_word_q  <= play_word_d;
      write_acc_q  <= write_acc_d;
    end
  end

  jrb_ram #(
    .Width (DataW),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Playout pipeline: pending stage waits for the RAM read data, then moves
  // into the output register. The RAM only reads on an accepted pull, so its
  // data holds while the pending stage is stalled.
  // --------------------------------------------------------------------------
  logic             pend_valid_q, pend_valid_d;
  play_t            pend_q;
  logic             out_valid_q, out_valid_d;
  play_t            out_q;
  logic [DataW-1:0] out_data_q;
  logic             out_adv;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  // Hold the input while the pending result cannot move on.
  assign s_axis_tready_o = !pend_valid_q || out_adv;

  always_comb begin
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    if (out_adv) begin
      out_valid_d  = pend_valid_q;
      pend_valid_d = 1'b0;
    end
    if (pull_beat) begin
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pull_beat) begin
      pend_q <= play_d;
    end
    if (out_adv && pend_valid_q) begin
      out_q      <= pend_q;
      out_data_q <= pend_q.valid_res ? ram_rdata : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_data_q, out_q.widx, out_q.seq};
  assign m_axis_tuser_o  = out_q.valid_res;
  assign m_axis_tlast_o  = out_q.frame_end;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= SlotW'(WINDOW - 1))
    else $error("next slot index beyond window");

  a_word_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_word_q <= PwW'(FRAME_WORDS - 1))
    else $error("play word counter beyond frame length");

  a_free_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && pw_last) |=> !slot_full_q[$past(next_slot_q)])
    else $error("played slot not freed after last word");

  a_read_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (pend_valid_q && pend_q.valid_res))
    else $error("store read without pending playout word");

  a_no_read_unfull : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (started_q && slot_full_q[next_slot_q] && !ram_we))
    else $error("store read of an empty slot");

endmodule
